// ===== design/ile_pkg.sv =====
// shared types and codes for the indexed list engine
package ile_pkg;

  // request action codes
  localparam logic [2:0] ACT_READ       = 3'd0;
  localparam logic [2:0] ACT_INS_HEAD   = 3'd1;
  localparam logic [2:0] ACT_INS_TAIL   = 3'd2;
  localparam logic [2:0] ACT_INS_AT     = 3'd3;
  localparam logic [2:0] ACT_DELETE     = 3'd4;

  // stream payload widths
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 48;
  localparam int VALUE_W     = 32;
  localparam int POS_W       = 12;
  localparam int LENGTH_W    = 11;

  localparam logic [VALUE_W-1:0] MISS_VALUE = '1;

  // what every cell does on a clock edge
  typedef enum logic [2:0] {
    CELL_HOLD   = 3'd0,
    CELL_INSERT = 3'd1,
    CELL_DELETE = 3'd2,
    CELL_LOAD   = 3'd3,
    CELL_SHIFT  = 3'd4
  } cell_op_t;

  typedef struct packed {
    cell_op_t           op;
    logic [VALUE_W-1:0] value;
  } cell_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_DONE = 3'b100
  } state_t;

endpackage

// ===== design/ile_cell.sv =====
// one list cell: holds one entry and one stage of the read chain
module ile_cell #(
  parameter int IDX = 0,
  parameter int CW  = 11
) (
  input  logic                     clk,
  input  ile_pkg::cell_ctrl_t      ctrl,
  input  logic [CW-1:0]            pos,
  input  logic [ile_pkg::VALUE_W-1:0] below,
  input  logic [ile_pkg::VALUE_W-1:0] above,
  input  logic [ile_pkg::VALUE_W-1:0] bus_above,
  output logic [ile_pkg::VALUE_W-1:0] entry,
  output logic [ile_pkg::VALUE_W-1:0] bus
);
  import ile_pkg::*;

  localparam logic [CW-1:0] MY_IDX = CW'(IDX);

  logic               at_pos;
  logic               past_pos;
  logic [VALUE_W-1:0] entry_next;
  logic [VALUE_W-1:0] bus_next;

  assign at_pos   = (pos == MY_IDX);
  assign past_pos = (pos < MY_IDX);

  always_comb begin
    entry_next = entry;
    bus_next   = bus;
    unique case (ctrl.op)
      CELL_INSERT: begin
        if (at_pos) begin
          entry_next = ctrl.value;
        end else if (past_pos) begin
          entry_next = below;
        end
      end
      CELL_DELETE: begin
        if (at_pos || past_pos) begin
          entry_next = above;
        end
      end
      CELL_LOAD:  bus_next = entry;
      CELL_SHIFT: bus_next = bus_above;
      CELL_HOLD:  ;
      default:    ;
    endcase
  end

  // payload only, no reset
  always_ff @(posedge clk) begin
    entry <= entry_next;
    bus   <= bus_next;
  end

endmodule

// ===== design/indexed_list_engine_top.sv =====
// top level of the indexed list engine: control, result staging and the cell row
//
//  channel | dir | group                     | tdata fields (low bit up)
//  --------+-----+---------------------------+----------------------------------------
//  request | in  | s_tvalid s_tready s_tdata | action[2:0] position[14:3] value[46:15]
//  result  | out | m_tvalid m_tready m_tdata | read_value[31:0] found[32] done_res[33]
//          |     |                           | full_drop[34] length[45:35]
//
//  inserts, deletes and misses update the cell row as they are accepted and stage their result;
//  back to back they sustain one item per cycle while the result side keeps up
//  a read that hits has the row load the read chain, which
//  then shifts one cell a cycle toward cell zero
//  synchronous reset clears the count, the state and the output valid; entries are
//  left as they are and only those below the count are ever read
//  a stalled result holds in the output register while one more item is accepted
module indexed_list_engine_top #(
  parameter int CAPACITY = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // action[2:0], position[14:3], value[46:15], zero pad [47]
  input  logic [47:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // read_value[31:0], found[32], done_res[33], full_drop[34], length[45:35], zero pad
  output logic [47:0] m_tdata
);
  import ile_pkg::*;

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int IW   = $clog2(CAPACITY);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;

  state_t state;
  state_t state_next;

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [IW-1:0] rd_cnt;
  logic [IW-1:0] rd_cnt_next;

  // staged result waiting for the output register
  logic [VALUE_W-1:0] pend_value;
  logic               pend_found;
  logic               pend_done;
  logic               pend_drop;
  logic [VALUE_W-1:0] pend_value_next;
  logic               pend_found_next;
  logic               pend_done_next;
  logic               pend_drop_next;

  // request fields
  logic [2:0]         act;
  logic [POS_W-1:0]   pos;
  logic [VALUE_W-1:0] val;

  logic            accept;
  logic            out_free;
  logic            pos_neg;
  logic [CMPW-1:0] pos_ext;
  logic [CMPW-1:0] cnt_ext;
  logic            in_range;
  logic            full;
  logic            ins_req;
  logic            ins_ok;
  logic [CMPW-1:0] ins_pt;

  cell_ctrl_t    ctrl;
  logic [CW-1:0] cell_pos;

  logic [VALUE_W-1:0] entry_q [CAPACITY];
  logic [VALUE_W-1:0] bus_q   [CAPACITY];
  logic [31:0]        count32;

  assign act = s_tdata[2:0];
  assign pos = s_tdata[14:3];
  assign val = s_tdata[46:15];

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE) || ((state == ST_DONE) && out_free);
  assign accept   = s_tvalid && s_tready;

  // position checks against the count
  assign pos_neg  = pos[POS_W-1];
  assign pos_ext  = CMPW'(pos[POS_W-2:0]);
  assign cnt_ext  = CMPW'(count);
  assign in_range = !pos_neg && (pos_ext < cnt_ext);
  assign full     = (count == CW'(CAPACITY));

  always_comb begin
    ins_req = 1'b0;
    ins_pt  = '0;
    unique case (act)
      ACT_INS_HEAD: ins_req = 1'b1;
      ACT_INS_TAIL: begin
        ins_req = 1'b1;
        ins_pt  = cnt_ext;
      end
      ACT_INS_AT: begin
        ins_pt  = pos_neg ? '0 : pos_ext;
        ins_req = (ins_pt <= cnt_ext);
      end
      default: ;
    endcase
  end

  assign ins_ok = ins_req && !full;

  always_comb begin
    state_next      = state;
    count_next      = count;
    rd_cnt_next     = rd_cnt;
    pend_value_next = pend_value;
    pend_found_next = pend_found;
    pend_done_next  = pend_done;
    pend_drop_next  = pend_drop;
    ctrl.op         = CELL_HOLD;
    ctrl.value      = val;
    cell_pos        = CW'(pos_ext);

    if (accept) begin
      pend_value_next = MISS_VALUE;
      pend_found_next = 1'b0;
      pend_done_next  = 1'b0;
      pend_drop_next  = 1'b0;
      state_next      = ST_DONE;
      if (act == ACT_READ) begin
        if (in_range) begin
          // load the read chain, then walk it down to cell zero
          ctrl.op     = CELL_LOAD;
          rd_cnt_next = pos_ext[IW-1:0];
          state_next  = ST_READ;
        end
      end else if (act == ACT_DELETE) begin
        if (in_range) begin
          ctrl.op        = CELL_DELETE;
          count_next     = count - CW'(1);
          pend_done_next = 1'b1;
        end
      end else if (ins_req) begin
        cell_pos = CW'(ins_pt);
        if (ins_ok) begin
          ctrl.op        = CELL_INSERT;
          count_next     = count + CW'(1);
          pend_done_next = 1'b1;
        end else begin
          pend_drop_next = 1'b1;
        end
      end
    end else begin
      priority case (1'b1)
        (state == ST_READ): begin
          if (rd_cnt == '0) begin
            pend_value_next = bus_q[0];
            pend_found_next = 1'b1;
            state_next      = ST_DONE;
          end else begin
            ctrl.op     = CELL_SHIFT;
            rd_cnt_next = rd_cnt - IW'(1);
          end
        end
        (state == ST_DONE): begin
          if (out_free) begin
            state_next = ST_IDLE;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    rd_cnt     <= rd_cnt_next;
    pend_value <= pend_value_next;
    pend_found <= pend_found_next;
    pend_done  <= pend_done_next;
    pend_drop  <= pend_drop_next;
  end

  // output register: the count already reflects the staged request
  assign count32 = 32'(count);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == ST_DONE) && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && out_free) begin
      m_tdata <= {2'b00, count32[LENGTH_W-1:0], pend_drop, pend_done, pend_found,
                  pend_value};
    end
  end

  // the cell row; the top cell never sees a live neighbor above
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VALUE_W-1:0] below_v;
    logic [VALUE_W-1:0] above_v;
    logic [VALUE_W-1:0] bus_above_v;

    if (i == 0) begin : g_first
      assign below_v = val;
    end else begin : g_mid_lo
      assign below_v = entry_q[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign above_v     = entry_q[i];
      assign bus_above_v = '0;
    end else begin : g_mid_hi
      assign above_v     = entry_q[i+1];
      assign bus_above_v = bus_q[i+1];
    end

    ile_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .pos       (cell_pos),
      .below     (below_v),
      .above     (above_v),
      .bus_above (bus_above_v),
      .entry     (entry_q[i]),
      .bus       (bus_q[i])
    );
  end

endmodule

// ===== design/ile_checker.sv =====
// port-level checks for the indexed list engine, bound to the top level
module ile_checker #(
  parameter int CAPACITY = 1024
) (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [47:0] s_tdata,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata
);

  // a waiting request stays offered with its data unchanged
  a_req_hold: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
    else $error("request changed while waiting");

  // a stalled result stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  // a read hit never also reports a list change or a drop
  a_found_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[32] |-> !m_tdata[33] && !m_tdata[34])
    else $error("found with done or drop");

  // a miss always carries the all-ones value
  a_miss_value: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[32] |-> m_tdata[31:0] == 32'hFFFF_FFFF)
    else $error("miss without all-ones value");

  // change and drop exclude each other, and the length stays in bounds
  a_len_flags: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[33] && m_tdata[34]) && (32'(m_tdata[45:35]) <= CAPACITY))
    else $error("bad flags or length");

endmodule

bind indexed_list_engine_top ile_checker #(.CAPACITY(CAPACITY)) u_ile_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
